>>> hdl/lsap_pkg.sv
// Package for the line sensor array position block.
// Holds widths, constants, register codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package lsap_pkg;

  localparam int MAX_LEDS       = 16;
  localparam int INTENSITY_BITS = 8;
  localparam int FULL_SCALE     = (1 << INTENSITY_BITS) - 1;

  localparam int IDX_W   = 5;
  localparam int M_W     = 4;
  localparam int RATIO_W = 8;
  localparam int WSUM_W  = 17;
  localparam int PROD_W  = 14;
  localparam int POS_FRAC = 14;
  localparam int DEN_W   = 15;
  localparam int NUM_W   = DEN_W + POS_FRAC;
  localparam int Q_W     = 15;
  localparam int POS_W   = 16;
  localparam int STEP_W  = 4;

  localparam logic REG_LED_COUNT   = 1'b0;
  localparam logic REG_SHARP_RATIO = 1'b1;

  localparam logic [IDX_W-1:0]   LED_COUNT_RESET   = 5'd8;
  localparam logic [RATIO_W-1:0] SHARP_RATIO_RESET = 8'd64;

  typedef struct packed {
    logic [IDX_W-1:0]   led_count;
    logic [RATIO_W-1:0] sharp_ratio;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/lsap_regs.sv
// APB-style configuration registers: led_count and sharp_ratio.
// Depends on lsap_pkg.
`default_nettype none
module lsap_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lsap_pkg::cfg_t    cfg_o
);
  import lsap_pkg::*;

  logic [IDX_W-1:0]   led_count_q;
  logic [RATIO_W-1:0] sharp_ratio_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= LED_COUNT_RESET;
      sharp_ratio_q <= SHARP_RATIO_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LED_COUNT:   led_count_q   <= pwdata[IDX_W-1:0];
        REG_SHARP_RATIO: sharp_ratio_q <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LED_COUNT:   prdata = {{(32-IDX_W){1'b0}}, led_count_q};
      REG_SHARP_RATIO: prdata = {{(32-RATIO_W){1'b0}}, sharp_ratio_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.led_count   = led_count_q;
  assign cfg_o.sharp_ratio = sharp_ratio_q;

endmodule
`default_nettype wire

>>> hdl/lsap_ctrl.sv
// Controller: accepts LED requests, sequences load, divide and store of a frame result.
// Depends on lsap_pkg.
`default_nettype none
module lsap_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  lsap_pkg::dp_status_t  status_i,
  output lsap_pkg::dp_cmd_t     cmd_o
);
  import lsap_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STORE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.load   = (state_q == ST_LOAD);
  assign cmd_o.step   = (state_q == ST_DIV);
  assign cmd_o.store  = (state_q == ST_STORE) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.store) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && status_i.last) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(Q_W - 1)) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsap_dp.sv
// Datapath: frame accumulators, edge flags, shift-subtract divider and result registers.
// Depends on lsap_pkg; driven by lsap_ctrl commands.
`default_nettype none
module lsap_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  lsap_pkg::cfg_t                cfg_i,
  input  lsap_pkg::dp_cmd_t             cmd_i,
  output lsap_pkg::dp_status_t          status_o,
  input  wire logic                     led_white_i,
  input  wire logic [7:0]               led_intensity_i,
  output logic signed [15:0]            line_position_o,
  output logic [4:0]                    dark_total_o,
  output logic                          no_line_o,
  output logic                          all_dark_o,
  output logic                          sharp_left_o,
  output logic                          sharp_right_o
);
  import lsap_pkg::*;

  logic [IDX_W-1:0]        idx_q;
  logic signed [WSUM_W-1:0] wsum_q;
  logic [IDX_W-1:0]        dark_q;
  logic signed [IDX_W-1:0] outer_q;
  logic                    seen_q;
  logic [5:0]              edge_q;

  logic [IDX_W-1:0]        n;
  logic [M_W-1:0]          m;
  logic [12:0]             thr_prod;
  logic [IDX_W-1:0]        thr_raw;
  logic [IDX_W-1:0]        thr;
  logic                    restart;
  logic [IDX_W-1:0]        idx;
  logic signed [WSUM_W-1:0] wsum_b;
  logic [IDX_W-1:0]        dark_b;
  logic signed [IDX_W-1:0] outer_b;
  logic                    seen_b;
  logic [5:0]              edge_b;
  logic [IDX_W:0]          idx_p1;
  logic signed [IDX_W-1:0] off;
  logic [IDX_W-1:0]        off_mag;
  logic [IDX_W-1:0]        outer_mag;
  logic [INTENSITY_BITS-1:0] weight;
  logic [PROD_W-1:0]       prod;
  logic [5:0]              edge_n;

  logic [NUM_W-1:0]        rem_q;
  logic [NUM_W-1:0]        dsh_q;
  logic [Q_W-1:0]          quo_q;
  logic                    neg_q;
  logic [IDX_W-1:0]        res_dark_q;
  logic [5:0]              res_edge_q;

  logic                    many;
  logic [WSUM_W-1:0]       wmag;
  logic [7:0]              cm;
  logic [15:0]             den_w;
  logic [DEN_W-1:0]        den;
  logic [NUM_W-1:0]        num;
  logic                    ge;
  logic [POS_W-1:0]        mag;

  always_comb begin
    if (cfg_i.led_count < IDX_W'(2)) begin
      n = IDX_W'(2);
    end else if (cfg_i.led_count > IDX_W'(MAX_LEDS)) begin
      n = IDX_W'(MAX_LEDS);
    end else begin
      n = cfg_i.led_count;
    end
  end

  assign m        = n[IDX_W-1:1];
  assign thr_prod = {8'b0, n} * {5'b0, cfg_i.sharp_ratio};
  assign thr_raw  = thr_prod[12:8];
  assign thr      = (thr_raw == '0) ? IDX_W'(1) : thr_raw;

  assign restart = (idx_q >= n);
  assign idx     = restart ? '0 : idx_q;
  assign wsum_b  = restart ? '0 : wsum_q;
  assign dark_b  = restart ? '0 : dark_q;
  assign outer_b = restart ? '0 : outer_q;
  assign seen_b  = restart ? 1'b0 : seen_q;
  assign edge_b  = restart ? 6'h3F : edge_q;

  assign idx_p1        = {1'b0, idx} + (IDX_W+1)'(1);
  assign status_o.last = (idx_p1 >= {1'b0, n});

  assign off       = idx - {1'b0, m};
  assign off_mag   = off[IDX_W-1] ? (IDX_W'(0) - off) : off;
  assign outer_mag = outer_b[IDX_W-1] ? (IDX_W'(0) - outer_b) : outer_b;
  assign weight    = INTENSITY_BITS'(FULL_SCALE) - led_intensity_i[INTENSITY_BITS-1:0];
  assign prod      = {{(PROD_W-IDX_W){off[IDX_W-1]}}, off} *
                     {{(PROD_W-INTENSITY_BITS){1'b0}}, weight};

  always_comb begin
    edge_n = edge_b;
    if (idx < thr) begin
      edge_n = edge_n & (led_white_i ? 6'h3E : 6'h3D);
    end
    if (({1'b0, idx} + {1'b0, thr}) > {1'b0, n}) begin
      edge_n = edge_n & (led_white_i ? 6'h37 : 6'h3B);
    end
    edge_n = edge_n & (led_white_i ? 6'h1F : 6'h2F);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      wsum_q  <= '0;
      dark_q  <= '0;
      outer_q <= '0;
      seen_q  <= 1'b0;
      edge_q  <= 6'h3F;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      wsum_q  <= '0;
      dark_q  <= '0;
      outer_q <= '0;
      seen_q  <= 1'b0;
      edge_q  <= 6'h3F;
    end else if (cmd_i.accept) begin
      idx_q  <= idx_p1[IDX_W-1:0];
      edge_q <= edge_n;
      if (!led_white_i) begin
        wsum_q <= wsum_b + {{(WSUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        dark_q <= dark_b + IDX_W'(1);
        seen_q <= 1'b1;
        outer_q <= (!seen_b || (off_mag > outer_mag)) ? off : outer_b;
      end else begin
        wsum_q  <= wsum_b;
        dark_q  <= dark_b;
        seen_q  <= seen_b;
        outer_q <= outer_b;
      end
    end
  end

  assign many  = (dark_q > IDX_W'(2));
  assign wmag  = wsum_q[WSUM_W-1] ? (WSUM_W'(0) - wsum_q) : wsum_q;
  assign cm    = {3'b0, dark_q} * {4'b0, m};
  assign den_w = 16'(cm) * 16'(FULL_SCALE);
  assign den   = many ? den_w[DEN_W-1:0] : {{(DEN_W-M_W){1'b0}}, m};
  assign num   = many ? {wmag[DEN_W-1:0], {POS_FRAC{1'b0}}}
                      : {{(DEN_W-IDX_W){1'b0}}, (outer_q[IDX_W-1] ? (IDX_W'(0) - outer_q)
                                                                : outer_q),
                         {POS_FRAC{1'b0}}};
  assign ge    = (rem_q >= dsh_q);
  assign mag   = {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q      <= num;
      dsh_q      <= {den, {POS_FRAC{1'b0}}};
      quo_q      <= '0;
      neg_q      <= many ? wsum_q[WSUM_W-1] : outer_q[IDX_W-1];
      res_dark_q <= dark_q;
      res_edge_q <= edge_q;
    end else if (cmd_i.step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[Q_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.store) begin
      line_position_o <= neg_q ? $signed(POS_W'(0) - mag) : $signed(mag);
      dark_total_o    <= res_dark_q;
      no_line_o       <= res_edge_q[4];
      all_dark_o      <= res_edge_q[5];
      sharp_left_o    <= res_edge_q[0] && res_edge_q[2];
      sharp_right_o   <= res_edge_q[1] && res_edge_q[3];
    end
  end

endmodule
`default_nettype wire

>>> hdl/line_sensor_array_position.sv
// Line position from a frame of reflectance sensors; top level.
// Throughput: one LED request per cycle within a frame; after the frame's last LED the
// input is held off through the load, 15 shift-subtract divider steps and the store,
// and for as long as the store waits on an unaccepted earlier result. The result and
// out_valid_o are registered in the store state. Reset: led_count 8, sharp_ratio 64,
// frame empty, no result pending. Uses lsap_pkg, lsap_regs, lsap_ctrl, lsap_dp.
`default_nettype none
module line_sensor_array_position (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               led_white_i,
  input  wire logic [7:0]         led_intensity_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      line_position_o,
  output logic [4:0]              dark_total_o,
  output logic                    no_line_o,
  output logic                    all_dark_o,
  output logic                    sharp_left_o,
  output logic                    sharp_right_o
);
  import lsap_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lsap_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lsap_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .led_white_i     (led_white_i),
    .led_intensity_i (led_intensity_i),
    .line_position_o (line_position_o),
    .dark_total_o    (dark_total_o),
    .no_line_o       (no_line_o),
    .all_dark_o      (all_dark_o),
    .sharp_left_o    (sharp_left_o),
    .sharp_right_o   (sharp_right_o)
  );

  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |=> out_valid_o)
    else $error("result store did not raise out_valid_o");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load || cmd.step) |-> !in_ready_o)
    else $error("LED request accepted while divider busy");

  a_last_starts_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && status.last) |=> cmd.load)
    else $error("frame end did not start result load");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_position_o <= 16'sd16384) && (line_position_o >= -16'sd16384))
    else $error("line_position_o out of range");

endmodule
`default_nettype wire

>>> dv/line_sensor_array_position_tb.sv
// Testbench for line_sensor_array_position: LED requests go in through a valid/ready
// driver, results are checked field by field against an in-bench frame predictor.
// Depends on lsap_pkg and the line_sensor_array_position RTL.
`timescale 1ns / 100ps
module line_sensor_array_position_tb;
  import lsap_pkg::*;

  typedef struct {
    logic       white;
    logic [7:0] intensity;
  } led_req_t;

  typedef struct {
    logic signed [15:0] position;
    logic [4:0]         dark_total;
    logic               no_line;
    logic               all_dark;
    logic               sharp_left;
    logic               sharp_right;
  } frame_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               led_white_i = 1'b0;
  logic [7:0]         led_intensity_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] line_position_o;
  logic [4:0]         dark_total_o;
  logic               no_line_o;
  logic               all_dark_o;
  logic               sharp_left_o;
  logic               sharp_right_o;

  line_sensor_array_position uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .led_white_i, .led_intensity_i,
    .out_valid_o, .out_ready_i, .line_position_o, .dark_total_o,
    .no_line_o, .all_dark_o, .sharp_left_o, .sharp_right_o
  );

  led_req_t      led_queue[$];
  frame_result_t frame_results_due[$];
  bit            led_taken = 1'b0;
  bit            steady = 1'b0;
  int            mismatches = 0;
  int            queued_count = 0;

  cfg_t   cfg_shadow;
  int     led_pos;
  longint wsum;
  int     dark_cnt;
  int     outer_off;
  bit     outer_hit;
  bit     left_dark, left_white, right_white, right_dark, every_white, every_dark;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int eff_leds();
    int n;
    n = cfg_shadow.led_count;
    if (n < 2) n = 2;
    if (n > MAX_LEDS) n = MAX_LEDS;
    return n;
  endfunction

  function automatic void clear_frame();
    led_pos = 0;
    wsum = 0;
    dark_cnt = 0;
    outer_off = 0;
    outer_hit = 1'b0;
    {left_dark, left_white, right_white, right_dark, every_white, every_dark} = '1;
  endfunction

  function automatic void track_led(input logic white, input logic [7:0] inten);
    int n, m, thr, off;
    longint pos;
    frame_result_t r;
    n = eff_leds();
    m = n / 2;
    thr = (n * int'(cfg_shadow.sharp_ratio)) >> 8;
    if (thr < 1) thr = 1;
    if (led_pos >= n) clear_frame();
    off = led_pos - m;
    if (!white) begin
      wsum += longint'(off * (FULL_SCALE - int'(inten)));
      dark_cnt++;
      if (!outer_hit || (off < 0 ? -off : off) > (outer_off < 0 ? -outer_off : outer_off)) begin
        outer_off = off;
        outer_hit = 1'b1;
      end
    end
    if (led_pos < thr) begin
      if (white) left_dark = 1'b0;
      else left_white = 1'b0;
    end
    if (led_pos + thr > n) begin
      if (white) right_dark = 1'b0;
      else right_white = 1'b0;
    end
    if (white) every_dark = 1'b0;
    else every_white = 1'b0;
    if (led_pos + 1 < n) begin
      led_pos++;
      return;
    end
    if (dark_cnt == 0) pos = 0;
    else if (dark_cnt <= 2) pos = (longint'(outer_off) << POS_FRAC) / m;
    else pos = (wsum << POS_FRAC) / (longint'(dark_cnt) * m * FULL_SCALE);
    r.position = pos[15:0];
    r.dark_total = dark_cnt[4:0];
    r.no_line = every_white;
    r.all_dark = every_dark;
    r.sharp_left = left_dark && right_white;
    r.sharp_right = left_white && right_dark;
    frame_results_due.push_back(r);
    clear_frame();
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] exp_v,
                                      input logic signed [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  always @(negedge clk_i) begin : drive_led
    led_req_t req;
    if (!in_valid_i || led_taken) begin
      if (rst_ni && led_queue.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
        req = led_queue.pop_front();
        in_valid_i <= 1'b1;
        led_white_i <= req.white;
        led_intensity_i <= req.intensity;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= steady || $urandom_range(99) >= 36;
  end

  always @(posedge clk_i) begin : watch_ports
    frame_result_t r;
    led_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no frame pending");
        end else begin
          r = frame_results_due.pop_front();
          check_field("line_position", r.position, line_position_o);
          check_field("dark_total", r.dark_total, dark_total_o);
          check_field("no_line", r.no_line, no_line_o);
          check_field("all_dark", r.all_dark, all_dark_o);
          check_field("sharp_left", r.sharp_left, sharp_left_o);
          check_field("sharp_right", r.sharp_right, sharp_right_o);
        end
      end
      if (in_valid_i && in_ready_o) track_led(led_white_i, led_intensity_i);
    end
  end

  task automatic queue_led(input logic white, input logic [7:0] inten);
    led_req_t req;
    req.white = white;
    req.intensity = inten;
    led_queue.push_back(req);
    queued_count++;
  endtask

  task automatic settle();
    while (led_queue.size() != 0 || in_valid_i || frame_results_due.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= idx == REG_LED_COUNT ? {27'($urandom), value[4:0]} : {24'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LED_COUNT) cfg_shadow.led_count = value[4:0];
    else cfg_shadow.sharp_ratio = value;
  endtask

  function automatic logic [7:0] pick_intensity();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_frame();
    int n, lo, hi, len;
    bit dark;
    n = eff_leds();
    len = n;
    if ($urandom_range(7) == 0) len = $urandom_range(n - 1, 1);
    case ($urandom_range(5))
      0: begin lo = -1; hi = -1; end
      1: begin lo = $urandom_range(n - 1); hi = lo + $urandom_range(3); end
      2: begin lo = 0; hi = $urandom_range(n - 1); end
      3: begin lo = $urandom_range(n - 1); hi = n - 1; end
      4: begin lo = 0; hi = n - 1; end
      default: begin lo = n; hi = n; end
    endcase
    for (int i = 0; i < len; i++) begin
      if (lo < 0) dark = $urandom_range(1);
      else dark = i >= lo && i <= hi;
      queue_led(!dark, pick_intensity());
    end
  endtask

  initial begin : stimulus
    logic [4:0] counts[10] = '{16, 3, 0, 31, 12, 1, 17, 7, 4, 9};
    logic [7:0] ratios[10] = '{128, 255, 0, 200, 64, 1, 90, 160, 32, 255};
    cfg_shadow.led_count = LED_COUNT_RESET;
    cfg_shadow.sharp_ratio = SHARP_RATIO_RESET;
    clear_frame();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: two dark on the left edge, rest white
    queue_led(1'b0, 8'd0);
    queue_led(1'b0, 8'd255);
    for (int i = 2; i < 8; i++) queue_led(1'b1, i == 7 ? 8'd255 : 8'd0);
    settle();
    write_reg(REG_LED_COUNT, 8'd2);
    write_reg(REG_SHARP_RATIO, 8'd255);
    queue_led(1'b1, 8'd0);
    queue_led(1'b1, 8'd255);
    queue_led(1'b0, 8'd17);
    queue_led(1'b1, 8'd200);
    queue_led(1'b0, 8'd0);
    queue_led(1'b0, 8'd255);
    settle();
    write_reg(REG_LED_COUNT, 8'd5);
    write_reg(REG_SHARP_RATIO, 8'd0);
    queue_led(1'b1, 8'd90);
    queue_led(1'b0, 8'd0);
    queue_led(1'b0, 8'd255);
    queue_led(1'b0, 8'd128);
    queue_led(1'b1, 8'd3);
    // drop a partial frame by lowering the count
    queue_led(1'b0, 8'd10);
    queue_led(1'b0, 8'd20);
    queue_led(1'b0, 8'd30);
    settle();
    write_reg(REG_LED_COUNT, 8'd3);
    queue_led(1'b0, 8'd40);
    queue_led(1'b1, 8'd250);
    queue_led(1'b0, 8'd5);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_LED_COUNT, 8'(counts[ph]));
      write_reg(REG_SHARP_RATIO, ph == 9 ? 8'($urandom_range(255)) : ratios[ph]);
      steady = ph == 5;
      queued_count = 0;
      while (queued_count < 65) queue_frame();
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
